### hw/rtl/wpt_pkg.sv
// Shared constants, codes and the result record of the weighted-prediction table parser.
`timescale 1ns / 1ps
package wpt_pkg;

  localparam int WPT_MAX_REFS = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_CHROMA_PRESENT = 2'd0;
  localparam logic [1:0] CFG_SLICE_KIND     = 2'd1;
  localparam logic [1:0] CFG_REFS_L0        = 2'd2;
  localparam logic [1:0] CFG_REFS_L1        = 2'd3;

  // slice kinds
  localparam logic [1:0] SLICE_B = 2'd0;
  localparam logic [1:0] SLICE_P = 2'd1;
  localparam logic [1:0] SLICE_I = 2'd2;

  // result kinds
  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // components
  localparam logic [1:0] COMP_Y    = 2'd0;
  localparam logic [1:0] COMP_CB   = 2'd1;
  localparam logic [1:0] COMP_CR   = 2'd2;
  localparam logic [1:0] COMP_DONE = 2'd3;

  // error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_LDENOM    = 3'd1;
  localparam logic [2:0] ERR_CDENOM    = 3'd2;
  localparam logic [2:0] ERR_WEIGHT    = 3'd3;
  localparam logic [2:0] ERR_OFFSET    = 3'd4;
  localparam logic [2:0] ERR_COFFSET   = 3'd5;
  localparam logic [2:0] ERR_FLAG_SUM  = 3'd6;

  localparam int FLAG_SUM_LIMIT = 24;
  localparam int OUT_TDATA_W    = 40;

  // one result item without its last marker
  typedef struct packed {
    logic              kind;
    logic              list_sel;
    logic [3:0]        ref_index;
    logic [1:0]        component;
    logic signed [8:0] weight;
    logic signed [7:0] offset;
    logic [2:0]        luma_denom;
    logic [2:0]        chroma_denom;
    logic [2:0]        error;
  } res_t;

endpackage

### hw/rtl/wpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wpt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/weighted_pred_table_parser.sv
// Top level: weighted-prediction table sequencer with flag RAMs and result buffering.
// A result made by a beat or step passes through the pending slot into the output register.
// Throughput: one syntax element per cycle while the result buffer has room; the sequencer
// makes default entries and the status beat one per cycle, holding input off as it walks them.
// Flags sit in two 1-bit RAMs with registered read data, addressed by the next position.
// Reset (rst_n low, synchronous) returns to waiting for a luma denominator; no RAM clearing.
`timescale 1ns / 1ps
module weighted_pred_table_parser
  import wpt_pkg::*;
#(
  parameter int MAX_REFS = WPT_MAX_REFS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_data,
  // syntax elements
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [15:0]            in_tdata,  // [15:0] value
  input  logic                   in_tuser,  // [0] first
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // [0] list_sel, [4:1] ref_index, [6:5] component,
                                            // [15:7] weight, [23:16] offset,
                                            // [26:24] luma_denom, [29:27] chroma_denom,
                                            // [32:30] error, [39:33] zero
  output logic                   out_tuser, // [0] kind
  output logic                   out_tlast
);

  localparam int CW = $clog2(MAX_REFS + 1);
  localparam int IW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int AW = IW + 1;
  localparam int RAM_DEPTH = 2 << IW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REFS);

  typedef enum logic [3:0] {
    PH_IDLE, PH_CDEN, PH_LFLAG, PH_CFLAG, PH_ENT,
    PH_LW, PH_LO, PH_CW, PH_CO, PH_FIN
  } phase_t;

  // configuration registers
  logic       chroma_present_r;
  logic [1:0] slice_kind_r;
  logic [3:0] refs_l0_r, refs_l1_r;

  // table state
  phase_t            phase_r, phase_nxt;
  logic              list_r, list_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic              t_chroma_r, t_chroma_nxt;
  logic [1:0]        t_kind_r, t_kind_nxt;
  logic [CW-1:0]     cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic [2:0]        ldenom_r, ldenom_nxt, cdenom_r, cdenom_nxt;
  logic signed [7:0] pend_w_r, pend_w_nxt;
  logic              pend_err_r, pend_err_nxt;
  logic [2:0]        sticky_r, sticky_nxt;
  logic [6:0]        fsum_r, fsum_nxt;

  // result buffering: pending slot and output register
  res_t pnd_r, out_r, em_res;
  logic pnd_vld_r, out_vld_r, out_last_r;
  logic em, em_fire, space, mv, wait_in, step_go, in_fire;

  // flag RAMs
  logic          lflag_we, cflag_we, lflag_rd, cflag_rd, flag_wd;
  logic [AW-1:0] flag_waddr, flag_raddr;

  // arithmetic on the incoming element
  logic signed [15:0] in_val;
  logic               lden_hit, cden_hit, v8_hit, d10_hit;
  logic [2:0]         lden_val, cden_val;
  logic signed [16:0] cd_sum;
  logic signed [7:0]  v8;
  logic signed [9:0]  d10;
  logic [8:0]         lpow, cpow;
  logic signed [8:0]  lw, cw;
  logic signed [17:0] cw_sh, co_full;
  logic signed [7:0]  co;
  logic [CW-1:0]      cnt_cur, c0_new, c1_new;
  logic [4:0]         c0_ext, c1_ext;
  logic               chk_err;
  logic [2:0]         lo_err, co_err;

  assign cfg_ready = 1'b1;
  assign in_val    = $signed(in_tdata);
  assign cnt_cur   = list_r ? cnt1_r : cnt0_r;

  // clamp the denominators
  assign lden_hit = (in_val < 16'sd0) || (in_val > 16'sd7);
  assign lden_val = (in_val < 16'sd0) ? 3'd0 : (in_val > 16'sd7) ? 3'd7 : in_val[2:0];
  assign cd_sum   = $signed({14'd0, ldenom_r}) + $signed({in_val[15], in_val});
  assign cden_hit = (cd_sum < 17'sd0) || (cd_sum > 17'sd7);
  assign cden_val = (cd_sum < 17'sd0) ? 3'd0 : (cd_sum > 17'sd7) ? 3'd7 : cd_sum[2:0];

  // clamp weight deltas, luma offsets and chroma offset deltas
  assign v8_hit  = (in_val < -16'sd128) || (in_val > 16'sd127);
  assign v8      = (in_val < -16'sd128) ? -8'sd128 :
                   (in_val > 16'sd127) ? 8'sd127 : in_val[7:0];
  assign d10_hit = (in_val < -16'sd512) || (in_val > 16'sd511);
  assign d10     = (in_val < -16'sd512) ? -10'sd512 :
                   (in_val > 16'sd511) ? 10'sd511 : in_val[9:0];

  // weights and the derived chroma offset
  assign lpow    = 9'd1 << ldenom_r;
  assign cpow    = 9'd1 << cdenom_r;
  assign lw      = $signed(lpow) + $signed({pend_w_r[7], pend_w_r});
  assign cw      = $signed(cpow) + $signed({pend_w_r[7], pend_w_r});
  assign cw_sh   = $signed({{9{cw[8]}}, cw}) <<< (3'd7 - cdenom_r);
  assign co_full = $signed({{8{d10[9]}}, d10}) - cw_sh + 18'sd128;
  assign co      = (co_full < -18'sd128) ? -8'sd128 :
                   (co_full > 18'sd127) ? 8'sd127 : co_full[7:0];
  assign lo_err  = pend_err_r ? ERR_WEIGHT : (v8_hit ? ERR_OFFSET : ERR_OK);
  assign co_err  = pend_err_r ? ERR_WEIGHT : (d10_hit ? ERR_COFFSET : ERR_OK);
  assign chk_err = (t_kind_r == SLICE_B || t_kind_r == SLICE_P) &&
                   (fsum_r > 7'(FLAG_SUM_LIMIT));

  // saturate reference counts
  assign c0_ext = {1'b0, refs_l0_r} + 5'd1;
  assign c1_ext = {1'b0, refs_l1_r} + 5'd1;
  assign c0_new = (c0_ext > 5'(MAX_REFS)) ? MAX_CNT : CW'(c0_ext);
  assign c1_new = (c1_ext > 5'(MAX_REFS)) ? MAX_CNT : CW'(c1_ext);

  // sequencer waits for input in these positions
  always_comb begin
    case (phase_r)
      PH_LFLAG, PH_CFLAG: wait_in = (idx_r < cnt_cur);
      PH_ENT, PH_FIN:     wait_in = 1'b0;
      default:            wait_in = 1'b1;
    endcase
  end

  assign space     = !out_vld_r || out_tready;
  assign in_tready = wait_in && (!pnd_vld_r || space);
  assign in_fire   = in_tvalid && in_tready;
  assign step_go   = !wait_in && (!pnd_vld_r || space);
  assign em_fire   = em;
  assign mv        = pnd_vld_r && space && (em_fire || wait_in);

  // flag writes at the current position, reads at the next one
  assign flag_wd    = (in_val != 16'sd0);
  assign lflag_we   = in_fire && !in_tuser && (phase_r == PH_LFLAG);
  assign cflag_we   = in_fire && !in_tuser && (phase_r == PH_CFLAG);
  assign flag_waddr = {list_r, idx_r[IW-1:0]};
  assign flag_raddr = {list_nxt, idx_nxt[IW-1:0]};

  wpt_ram #(.WIDTH(1), .DEPTH(RAM_DEPTH)) u_lflag_ram (
    .clk   (clk),
    .we    (lflag_we),
    .waddr (flag_waddr),
    .wdata (flag_wd),
    .raddr (flag_raddr),
    .rdata (lflag_rd)
  );

  wpt_ram #(.WIDTH(1), .DEPTH(RAM_DEPTH)) u_cflag_ram (
    .clk   (clk),
    .we    (cflag_we),
    .waddr (flag_waddr),
    .wdata (flag_wd),
    .raddr (flag_raddr),
    .rdata (cflag_rd)
  );

  // take one beat or make one sequencing step
  always_comb begin
    phase_nxt    = phase_r;
    list_nxt     = list_r;
    idx_nxt      = idx_r;
    comp_nxt     = comp_r;
    t_chroma_nxt = t_chroma_r;
    t_kind_nxt   = t_kind_r;
    cnt0_nxt     = cnt0_r;
    cnt1_nxt     = cnt1_r;
    ldenom_nxt   = ldenom_r;
    cdenom_nxt   = cdenom_r;
    pend_w_nxt   = pend_w_r;
    pend_err_nxt = pend_err_r;
    sticky_nxt   = sticky_r;
    fsum_nxt     = fsum_r;
    em           = 1'b0;
    em_res.kind         = KIND_ENTRY;
    em_res.list_sel     = list_r;
    em_res.ref_index    = 4'(idx_r);
    em_res.component    = comp_r;
    em_res.weight       = '0;
    em_res.offset       = '0;
    em_res.luma_denom   = ldenom_r;
    em_res.chroma_denom = cdenom_r;
    em_res.error        = ERR_OK;

    if (in_fire) begin
      if (in_tuser) begin
        // start a new table
        t_chroma_nxt = chroma_present_r;
        t_kind_nxt   = slice_kind_r;
        cnt0_nxt     = c0_new;
        cnt1_nxt     = c1_new;
        ldenom_nxt   = lden_val;
        sticky_nxt   = lden_hit ? ERR_LDENOM : ERR_OK;
        cdenom_nxt   = 3'd0;
        fsum_nxt     = '0;
        list_nxt     = 1'b0;
        idx_nxt      = '0;
        comp_nxt     = COMP_Y;
        if (chroma_present_r) begin
          phase_nxt = PH_CDEN;
        end else begin
          phase_nxt = (slice_kind_r == SLICE_B || slice_kind_r == SLICE_P) ? PH_LFLAG : PH_FIN;
        end
      end else begin
        unique case (phase_r)
          PH_CDEN: begin
            cdenom_nxt = cden_val;
            if (cden_hit && sticky_r == ERR_OK) sticky_nxt = ERR_CDENOM;
            list_nxt  = 1'b0;
            idx_nxt   = '0;
            comp_nxt  = COMP_Y;
            phase_nxt = (t_kind_r == SLICE_B || t_kind_r == SLICE_P) ? PH_LFLAG : PH_FIN;
          end
          PH_LFLAG: begin
            fsum_nxt = fsum_r + 7'(flag_wd);
            idx_nxt  = idx_r + 1'b1;
          end
          PH_CFLAG: begin
            fsum_nxt = fsum_r + (flag_wd ? 7'd2 : 7'd0);
            idx_nxt  = idx_r + 1'b1;
          end
          PH_LW, PH_CW: begin
            pend_w_nxt   = v8;
            pend_err_nxt = v8_hit;
            phase_nxt    = (phase_r == PH_LW) ? PH_LO : PH_CO;
          end
          PH_LO: begin
            em            = 1'b1;
            em_res.weight = lw;
            em_res.offset = v8;
            em_res.error  = lo_err;
            if (lo_err != ERR_OK && sticky_r == ERR_OK) sticky_nxt = lo_err;
            comp_nxt  = t_chroma_r ? COMP_CB : COMP_DONE;
            phase_nxt = PH_ENT;
          end
          PH_CO: begin
            em            = 1'b1;
            em_res.weight = cw;
            em_res.offset = co;
            em_res.error  = co_err;
            if (co_err != ERR_OK && sticky_r == ERR_OK) sticky_nxt = co_err;
            comp_nxt  = comp_r + 2'd1;
            phase_nxt = PH_ENT;
          end
          default: ;
        endcase
      end
    end else if (step_go) begin
      unique case (phase_r)
        PH_LFLAG: begin
          idx_nxt   = '0;
          comp_nxt  = COMP_Y;
          phase_nxt = t_chroma_r ? PH_CFLAG : PH_ENT;
        end
        PH_CFLAG: begin
          idx_nxt   = '0;
          comp_nxt  = COMP_Y;
          phase_nxt = PH_ENT;
        end
        PH_ENT: begin
          if (idx_r >= cnt_cur) begin
            // end of this list
            if (!list_r && t_kind_r == SLICE_B) begin
              list_nxt  = 1'b1;
              idx_nxt   = '0;
              phase_nxt = PH_LFLAG;
            end else begin
              phase_nxt = PH_FIN;
            end
          end else if (comp_r == COMP_Y) begin
            if (lflag_rd) begin
              phase_nxt = PH_LW;
            end else begin
              em            = 1'b1;
              em_res.weight = $signed(lpow);
              comp_nxt      = t_chroma_r ? COMP_CB : COMP_DONE;
            end
          end else if (comp_r == COMP_DONE) begin
            idx_nxt  = idx_r + 1'b1;
            comp_nxt = COMP_Y;
          end else begin
            if (cflag_rd) begin
              phase_nxt = PH_CW;
            end else begin
              em            = 1'b1;
              em_res.weight = $signed(cpow);
              comp_nxt      = comp_r + 2'd1;
            end
          end
        end
        PH_FIN: begin
          // status beat closes the table
          em                  = 1'b1;
          em_res.kind         = KIND_STATUS;
          em_res.list_sel     = 1'b0;
          em_res.ref_index    = '0;
          em_res.component    = COMP_Y;
          em_res.error        = (sticky_r != ERR_OK) ? sticky_r :
                                (chk_err ? ERR_FLAG_SUM : ERR_OK);
          list_nxt  = 1'b0;
          idx_nxt   = '0;
          comp_nxt  = COMP_Y;
          phase_nxt = PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // state, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_present_r <= 1'b1;
      slice_kind_r     <= SLICE_I;
      refs_l0_r        <= '0;
      refs_l1_r        <= '0;
      phase_r          <= PH_IDLE;
      list_r           <= 1'b0;
      idx_r            <= '0;
      comp_r           <= COMP_Y;
      t_chroma_r       <= 1'b0;
      t_kind_r         <= SLICE_B;
      cnt0_r           <= '0;
      cnt1_r           <= '0;
      ldenom_r         <= '0;
      cdenom_r         <= '0;
      pend_w_r         <= '0;
      pend_err_r       <= 1'b0;
      sticky_r         <= ERR_OK;
      fsum_r           <= '0;
      pnd_vld_r        <= 1'b0;
      out_vld_r        <= 1'b0;
      out_last_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CHROMA_PRESENT: chroma_present_r <= cfg_data[0];
          CFG_SLICE_KIND:     slice_kind_r     <= cfg_data[1:0];
          CFG_REFS_L0:        refs_l0_r        <= cfg_data;
          CFG_REFS_L1:        refs_l1_r        <= cfg_data;
          default: ;
        endcase
      end
      phase_r    <= phase_nxt;
      list_r     <= list_nxt;
      idx_r      <= idx_nxt;
      comp_r     <= comp_nxt;
      t_chroma_r <= t_chroma_nxt;
      t_kind_r   <= t_kind_nxt;
      cnt0_r     <= cnt0_nxt;
      cnt1_r     <= cnt1_nxt;
      ldenom_r   <= ldenom_nxt;
      cdenom_r   <= cdenom_nxt;
      pend_w_r   <= pend_w_nxt;
      pend_err_r <= pend_err_nxt;
      sticky_r   <= sticky_nxt;
      fsum_r     <= fsum_nxt;

      // advance the pending result; it is the last of its step once the sequencer waits
      if (mv) begin
        out_vld_r  <= 1'b1;
        out_last_r <= wait_in;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (em_fire) begin
        pnd_vld_r <= 1'b1;
      end else if (mv) begin
        pnd_vld_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (mv) out_r <= pnd_r;
    if (em_fire) pnd_r <= em_res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_r.error, out_r.chroma_denom, out_r.luma_denom,
                       out_r.offset, out_r.weight, out_r.component, out_r.ref_index,
                       out_r.list_sel};

`ifndef NO_ASSERTIONS
  // a new result never lands on a pending one that cannot move
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    em_fire |-> (!pnd_vld_r || mv))
    else $error("pending result overwritten");

  // a status beat always closes its step
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("status beat without last");

  // position never runs past the list length
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LFLAG || phase_r == PH_CFLAG || phase_r == PH_ENT) |-> (idx_r <= cnt_cur))
    else $error("reference position beyond list");

  // status beat leaves the sequencer idle
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FIN && step_go) |=> (phase_r == PH_IDLE && pnd_vld_r))
    else $error("status step did not return to idle");
`endif

endmodule

### tb/sv/tb_weighted_pred_table_parser.sv
// Self-checking testbench for the weighted-prediction table parser with a built-in predictor.
`timescale 1ns / 1ps
module tb_weighted_pred_table_parser;
  import wpt_pkg::*;

  localparam int IDLE_PCT   = 31;
  localparam int HOLD_OFF   = 400;
  localparam int DRAIN_WAIT = 12;
  localparam int WD_LIMIT   = 3000;
  localparam int N_ITEMS    = 470;

  typedef enum int {S_IDLE, S_CDEN, S_LFLAG, S_CFLAG, S_ENT, S_LW, S_LO, S_CW, S_CO, S_FIN}
    seq_state_t;

  typedef struct {
    logic [15:0] value;
    logic        first;
  } elem_t;

  typedef struct {
    res_t r;
    logic last;
  } entry_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [3:0]       cfg_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [15:0]      in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tlast;

  elem_t  elem_q[$];
  entry_t entry_q[$];
  int     fail_cnt = 0;
  int     sent = 0;
  bit     quiet = 1'b0;
  bit     in_took = 1'b0;
  int     stall_ask = 0;
  int     stall_seen = 0;
  int     stall_left = 0;
  int     wd_cnt = 0;

  // register copies and table sequencing state of the predictor
  logic       reg_chroma = 1'b1;
  logic [1:0] reg_kind = SLICE_I;
  logic [3:0] reg_r0 = '0;
  logic [3:0] reg_r1 = '0;
  logic       t_chroma;
  logic [1:0] t_kind;
  int         t_cnt[2];
  seq_state_t st = S_IDLE;
  int         cur_list, cur_idx, cur_comp;
  int         ldenom, cdenom, pend_w;
  logic [2:0] pend_err, sticky;
  bit         lflag[2][16];
  bit         cflag[2][16];
  int         n_made;

  weighted_pred_table_parser u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clip(int v, int lo, int hi, inout bit hit);
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function void note_err(logic [2:0] e);
    if (sticky == ERR_OK) sticky = e;
  endfunction

  function void add_entry(logic kind, int w, int o, logic [2:0] e);
    entry_t x;
    x.r.kind         = kind;
    x.r.list_sel     = kind ? 1'b0 : cur_list[0];
    x.r.ref_index    = kind ? 4'd0 : cur_idx[3:0];
    x.r.component    = kind ? 2'd0 : cur_comp[1:0];
    x.r.weight       = w[8:0];
    x.r.offset       = o[7:0];
    x.r.luma_denom   = ldenom[2:0];
    x.r.chroma_denom = cdenom[2:0];
    x.r.error        = e;
    x.last           = 1'b0;
    entry_q.push_back(x);
    n_made++;
  endfunction

  function int flag_total();
    int s;
    s = 0;
    for (int l = 0; l < ((t_kind == SLICE_B) ? 2 : 1); l++)
      for (int i = 0; i < t_cnt[l]; i++) begin
        s += lflag[l][i];
        if (t_chroma) s += 2 * cflag[l][i];
      end
    return s;
  endfunction

  function void begin_lists();
    cur_list = 0;
    cur_idx  = 0;
    cur_comp = 0;
    st = (t_kind <= SLICE_P) ? S_LFLAG : S_FIN;
  endfunction

  // walk forward through default entries until an element is needed
  function void walk_defaults();
    logic [2:0] e;
    forever begin
      case (st)
        S_LFLAG: begin
          if (cur_idx < t_cnt[cur_list]) return;
          cur_idx  = 0;
          cur_comp = 0;
          st = t_chroma ? S_CFLAG : S_ENT;
        end
        S_CFLAG: begin
          if (cur_idx < t_cnt[cur_list]) return;
          cur_idx  = 0;
          cur_comp = 0;
          st = S_ENT;
        end
        S_ENT: begin
          if (cur_idx >= t_cnt[cur_list]) begin
            if (cur_list == 0 && t_kind == SLICE_B) begin
              cur_list = 1;
              cur_idx  = 0;
              st = S_LFLAG;
            end else begin
              st = S_FIN;
            end
          end else if (cur_comp == COMP_Y) begin
            if (lflag[cur_list][cur_idx]) begin
              st = S_LW;
              return;
            end
            add_entry(KIND_ENTRY, 1 << ldenom, 0, ERR_OK);
            cur_comp = t_chroma ? COMP_CB : COMP_DONE;
          end else if (cur_comp <= COMP_CR) begin
            if (cflag[cur_list][cur_idx]) begin
              st = S_CW;
              return;
            end
            add_entry(KIND_ENTRY, 1 << cdenom, 0, ERR_OK);
            cur_comp++;
          end else begin
            cur_idx++;
            cur_comp = 0;
          end
        end
        S_FIN: begin
          e = sticky;
          if (e == ERR_OK && t_kind <= SLICE_P && flag_total() > FLAG_SUM_LIMIT)
            e = ERR_FLAG_SUM;
          cur_list = 0;
          cur_idx  = 0;
          cur_comp = 0;
          add_entry(KIND_STATUS, 0, 0, e);
          st = S_IDLE;
          return;
        end
        default: return;
      endcase
    end
  endfunction

  // advance the predicted sequencer by one accepted element
  function void predict_elem(logic [15:0] value, logic first);
    int v, o, w, d;
    bit hit;
    logic [2:0] e;
    v = $signed(value);
    hit = 1'b0;
    n_made = 0;
    if (first) begin
      t_chroma = reg_chroma;
      t_kind   = reg_kind;
      t_cnt[0] = reg_r0 + 1;
      t_cnt[1] = reg_r1 + 1;
      sticky   = ERR_OK;
      ldenom   = clip(v, 0, 7, hit);
      if (hit) note_err(ERR_LDENOM);
      cdenom = 0;
      if (t_chroma) st = S_CDEN;
      else begin_lists();
    end else begin
      case (st)
        S_CDEN: begin
          cdenom = clip(ldenom + v, 0, 7, hit);
          if (hit) note_err(ERR_CDENOM);
          begin_lists();
        end
        S_LFLAG: begin
          lflag[cur_list][cur_idx & 15] = (v != 0);
          cur_idx++;
        end
        S_CFLAG: begin
          cflag[cur_list][cur_idx & 15] = (v != 0);
          cur_idx++;
        end
        S_LW, S_CW: begin
          pend_w   = clip(v, -128, 127, hit);
          pend_err = hit ? ERR_WEIGHT : ERR_OK;
          st = (st == S_LW) ? S_LO : S_CO;
        end
        S_LO: begin
          o = clip(v, -128, 127, hit);
          e = (pend_err != ERR_OK) ? pend_err : (hit ? ERR_OFFSET : ERR_OK);
          if (e != ERR_OK) note_err(e);
          add_entry(KIND_ENTRY, (1 << ldenom) + pend_w, o, e);
          cur_comp = t_chroma ? COMP_CB : COMP_DONE;
          st = S_ENT;
        end
        S_CO: begin
          d = clip(v, -512, 511, hit);
          e = (pend_err != ERR_OK) ? pend_err : (hit ? ERR_COFFSET : ERR_OK);
          w = (1 << cdenom) + pend_w;
          hit = 1'b0;
          o = clip(d - w * (1 << (7 - cdenom)) + 128, -128, 127, hit);
          if (e != ERR_OK) note_err(e);
          add_entry(KIND_ENTRY, w, o, e);
          cur_comp++;
          st = S_ENT;
        end
        default: ;
      endcase
    end
    walk_defaults();
    if (n_made > 0) entry_q[entry_q.size() - 1].last = 1'b1;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // sample accepted beats, predict on input, compare on output
  always @(posedge clk) begin
    entry_t x;
    bit out_took;
    in_took  = rst_n && in_tvalid && in_tready;
    out_took = rst_n && out_tvalid && out_tready;
    if (in_took) begin
      predict_elem(in_tdata, in_tuser);
      void'(elem_q.pop_front());
    end
    if (out_took) begin
      if (entry_q.size() == 0) begin
        $error("result beat with nothing pending: tdata %h", out_tdata);
        fail_cnt++;
      end else begin
        x = entry_q.pop_front();
        check_field("kind", x.r.kind, out_tuser);
        check_field("list_sel", x.r.list_sel, out_tdata[0]);
        check_field("ref_index", x.r.ref_index, out_tdata[4:1]);
        check_field("component", x.r.component, out_tdata[6:5]);
        check_field("weight", x.r.weight, $signed(out_tdata[15:7]));
        check_field("offset", x.r.offset, $signed(out_tdata[23:16]));
        check_field("luma_denom", x.r.luma_denom, out_tdata[26:24]);
        check_field("chroma_denom", x.r.chroma_denom, out_tdata[29:27]);
        check_field("error", x.r.error, out_tdata[32:30]);
        check_field("last", x.last, out_tlast);
      end
    end
    // watchdog on cycles without any beat
    if (in_took || out_took || (cfg_valid && cfg_ready)) begin
      wd_cnt = 0;
    end else begin
      wd_cnt++;
      if (wd_cnt >= WD_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // input driver: hold the beat until taken, idle at random
  always @(negedge clk) begin
    if (!in_tvalid || in_took) begin
      if (elem_q.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= elem_q[0].value;
        in_tuser  <= elem_q[0].first;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (stall_ask != stall_seen) begin
      stall_seen = stall_ask;
      stall_left = HOLD_OFF;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic chroma, logic [1:0] kind, logic [3:0] r0, logic [3:0] r1);
    write_reg(CFG_CHROMA_PRESENT, {3'b0, chroma});
    write_reg(CFG_SLICE_KIND, {2'b0, kind});
    write_reg(CFG_REFS_L0, r0);
    write_reg(CFG_REFS_L1, r1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_chroma = chroma;
    reg_kind   = kind;
    reg_r0     = r0;
    reg_r1     = r1;
  endtask

  task automatic push_elem(int v, logic first);
    elem_t e;
    e.value = v[15:0];
    e.first = first;
    elem_q.push_back(e);
    sent++;
  endtask

  // in range most of the time, any 16-bit value now and then
  function automatic int pick(int lo, int hi);
    if ($urandom_range(99) < 7) return $signed(16'($urandom));
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // one table in bitstream order for the current registers, maybe cut short
  task automatic push_table(int flag_pct);
    elem_t seq[$];
    elem_t e;
    bit lf[16], cf[16];
    int ld, nl, cnt, keep;
    ld = pick(0, 7);
    e.first = 1'b1;
    e.value = ld[15:0];
    seq.push_back(e);
    e.first = 1'b0;
    if (ld < 0 || ld > 7) ld = 0;
    if (reg_chroma) begin
      e.value = 16'(pick(-ld, 7 - ld));
      seq.push_back(e);
    end
    nl = (reg_kind == SLICE_B) ? 2 : (reg_kind == SLICE_P) ? 1 : 0;
    for (int l = 0; l < nl; l++) begin
      cnt = ((l == 0) ? reg_r0 : reg_r1) + 1;
      for (int i = 0; i < cnt; i++) begin
        lf[i] = ($urandom_range(99) < flag_pct);
        e.value = lf[i] ? 16'($urandom_range(65535, 1)) : 16'd0;
        seq.push_back(e);
      end
      if (reg_chroma)
        for (int i = 0; i < cnt; i++) begin
          cf[i] = ($urandom_range(99) < flag_pct);
          e.value = cf[i] ? 16'($urandom_range(65535, 1)) : 16'd0;
          seq.push_back(e);
        end
      for (int i = 0; i < cnt; i++) begin
        if (lf[i]) begin
          e.value = 16'(pick(-128, 127));
          seq.push_back(e);
          e.value = 16'(pick(-128, 127));
          seq.push_back(e);
        end
        if (reg_chroma && cf[i])
          for (int c = 0; c < 2; c++) begin
            e.value = 16'(pick(-128, 127));
            seq.push_back(e);
            e.value = 16'(pick(-512, 511));
            seq.push_back(e);
          end
      end
    end
    // cut short now and then so the next table abandons this one
    keep = ($urandom_range(99) < 8) ? $urandom_range(seq.size(), 1) : seq.size();
    for (int i = 0; i < keep; i++) push_elem($signed(seq[i].value), seq[i].first);
    // stray element while idle, ignored by the block
    if (keep == seq.size() && $urandom_range(99) < 10) begin
      e.value = 16'($urandom);
      e.first = 1'b0;
      elem_q.push_back(e);
    end
  endtask

  task automatic drain();
    while (elem_q.size() > 0 || entry_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    int ph;
    logic [1:0] kinds[6];
    kinds = '{SLICE_B, SLICE_B, SLICE_P, SLICE_P, SLICE_I, 2'd3};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: P slice, two refs, extremes of weights and offsets
    configure(1'b1, SLICE_P, 4'd1, 4'd0);
    push_elem(7, 1'b1);
    push_elem(0, 1'b0);
    push_elem(1, 1'b0);
    push_elem(0, 1'b0);
    push_elem(-1, 1'b0);
    push_elem(1, 1'b0);
    push_elem(127, 1'b0);
    push_elem(-128, 1'b0);
    push_elem(-128, 1'b0);
    push_elem(511, 1'b0);
    push_elem(32767, 1'b0);
    push_elem(-32768, 1'b0);
    push_elem(0, 1'b0);
    push_elem(-512, 1'b0);
    push_elem(-129, 1'b0);
    push_elem(512, 1'b0);
    // bad luma denominator, then abandoned by a new table with bad chroma delta
    push_elem(-1, 1'b1);
    push_elem(100, 1'b0);
    push_elem(8, 1'b1);
    push_elem(-20, 1'b0);
    repeat (4) push_elem(0, 1'b0);
    push_elem(-32768, 1'b0);
    drain();

    // random phases across register settings
    ph = 0;
    while (sent < N_ITEMS) begin
      if (ph == 1) begin
        configure(1'b1, SLICE_B, 4'd15, 4'd15);
        push_table(100);
        stall_ask++;
      end else if (ph == 2) begin
        configure(1'b0, SLICE_B, 4'd0, 4'd0);
        quiet = 1'b1;
        repeat (6) push_table(50);
      end else begin
        configure($urandom_range(1), kinds[$urandom_range(5)],
                  ($urandom_range(99) < 85) ? 4'($urandom_range(3)) : 4'($urandom_range(15)),
                  ($urandom_range(99) < 85) ? 4'($urandom_range(3)) : 4'($urandom_range(15)));
        repeat (3) push_table($urandom_range(2) * 50);
      end
      drain();
      quiet = 1'b0;
      ph++;
    end

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### weighted_pred_table_parser.f
hw/rtl/wpt_pkg.sv
hw/rtl/wpt_ram.sv
hw/rtl/weighted_pred_table_parser.sv
tb/sv/tb_weighted_pred_table_parser.sv
